/* rtl/mrs_pkg.sv */
// Shared types, constants and the CRC-16 step for the Modbus RTU read responder.
// No dependencies; imported by the core, queue, front, back and the testbench.
`default_nettype none
package mrs_pkg;

  localparam int POINTS_DEF       = 1024;
  localparam int MAX_RESPONSE_DEF = 64;
  localparam int MAX_FRAME_DEF    = 256;
  localparam int INDEX_W          = 10;
  localparam int STORE_MAX        = 1 << INDEX_W;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  localparam logic [7:0] EXC_FUNC = 8'd1;
  localparam logic [7:0] EXC_ADDR = 8'd2;
  localparam logic [7:0] EXC_SIZE = 8'd3;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_WBIT = 2'd1,
    OP_WREG = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_BITS_FC    = 3'd0,
    CFG_REGS_FC    = 3'd1,
    CFG_BIT_BASE   = 3'd2,
    CFG_BIT_COUNT  = 3'd3,
    CFG_BIT_OFFSET = 3'd4,
    CFG_REG_BASE   = 3'd5,
    CFG_REG_COUNT  = 3'd6,
    CFG_REG_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  bits_fc;
    logic [7:0]  regs_fc;
    logic [15:0] bit_base;
    logic [10:0] bit_count;
    logic [9:0]  bit_offset;
    logic [15:0] reg_base;
    logic [10:0] reg_count;
    logic [9:0]  reg_offset;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WBIT = 2'd0,
    CMD_WREG = 2'd1,
    CMD_READ = 2'd2,
    CMD_EXC  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        regs;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [7:0]  code;
    logic [10:0] rel;
    logic [10:0] qty;
    logic [7:0]  bytecnt;
    logic [9:0]  index;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic {
    F_IN    = 1'b0,
    F_CHECK = 1'b1
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR = 4'd0,
    B_IDLE  = 4'd1,
    B_HEAD  = 4'd2,
    B_BREQ  = 4'd3,
    B_BCAP  = 4'd4,
    B_RREQ  = 4'd5,
    B_RCAP  = 4'd6,
    B_DATA  = 4'd7,
    B_CRCL  = 4'd8,
    B_CRCH  = 4'd9
  } back_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/mrs_if.sv */
// Valid/ready channel interfaces: request items in, response bytes out.
// Depends on nothing.
`default_nettype none
interface mrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic [9:0]  point_index;
  logic [15:0] point_value;
  modport source (output valid, op, rx_byte, frame_end, point_index, point_value,
                  input ready);
  modport sink   (input valid, op, rx_byte, frame_end, point_index, point_value,
                  output ready);
endinterface

interface mrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;
  modport source (output valid, tx_byte, tx_last, input ready);
  modport sink   (input valid, tx_byte, tx_last, output ready);
endinterface
`default_nettype wire

/* rtl/modbus_rtu_slave_read_responder_core.sv */
// With the queue empty and the back idle, the front classifies a frame once its last byte
// is accepted and queues the request, which the back pops to start the response; header
// and CRC bytes follow one per cycle while the output is not stalled, each bit point takes
// a store read and a capture, each packed byte is then emitted, and each register takes a
// read, a capture, a high byte and a low byte. Output stalls hold the response. Input:
// one item per cycle while the command queue has room, none while the front classifies
// a frame's last byte. Reset (rst, synchronous): clears control state, then sweeps all
// min(POINTS,1024) entries of both stores to zero, one per cycle, with input ready held low.
`default_nettype none
module modbus_rtu_slave_read_responder_core #(
  parameter int POINTS       = mrs_pkg::POINTS_DEF,
  parameter int MAX_RESPONSE = mrs_pkg::MAX_RESPONSE_DEF,
  parameter int MAX_FRAME    = mrs_pkg::MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  mrs_in_if.sink           items,
  mrs_out_if.source        results
);
  import mrs_pkg::*;

  cfg_t         cfg;
  cmd_t         push_cmd, head_cmd;
  logic         push, full, pop, empty;
  back_status_t bstat;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{bits_fc: 8'd2, regs_fc: 8'd3, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BITS_FC:    cfg.bits_fc    <= cfg_data[7:0];
        CFG_REGS_FC:    cfg.regs_fc    <= cfg_data[7:0];
        CFG_BIT_BASE:   cfg.bit_base   <= cfg_data;
        CFG_BIT_COUNT:  cfg.bit_count  <= cfg_data[10:0];
        CFG_BIT_OFFSET: cfg.bit_offset <= cfg_data[9:0];
        CFG_REG_BASE:   cfg.reg_base   <= cfg_data;
        CFG_REG_COUNT:  cfg.reg_count  <= cfg_data[10:0];
        CFG_REG_OFFSET: cfg.reg_offset <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Front: frame tracking and request classification.
  mrs_front #(
    .MAX_FRAME    (MAX_FRAME),
    .MAX_RESPONSE (MAX_RESPONSE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .bstat    (bstat),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue of store writes and classified requests, kept in arrival order.
  mrs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (empty)
  );

  // Back: stores, response byte generation, output register.
  mrs_back #(
    .POINTS (POINTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head_cmd (head_cmd),
    .empty    (empty),
    .pop      (pop),
    .bstat    (bstat),
    .results  (results)
  );
endmodule
`default_nettype wire

/* rtl/mrs_fifo.sv */
// Short command queue between front and back.
// Depends on mrs_pkg.
`default_nettype none
module mrs_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire mrs_pkg::cmd_t din,
  output logic              full,
  input  wire logic         pop,
  output mrs_pkg::cmd_t     dout,
  output logic              empty
);
  import mrs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

/* rtl/mrs_front.sv */
// Front end: takes items, tracks frame CRC/length/header, classifies requests.
// Depends on mrs_pkg and mrs_if.
`default_nettype none
module mrs_front #(
  parameter int MAX_FRAME    = mrs_pkg::MAX_FRAME_DEF,
  parameter int MAX_RESPONSE = mrs_pkg::MAX_RESPONSE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mrs_in_if.sink                    items,
  input  wire mrs_pkg::cfg_t        cfg,
  input  wire mrs_pkg::back_status_t bstat,
  input  wire logic                 full,
  output logic                      push,
  output mrs_pkg::cmd_t             push_cmd
);
  import mrs_pkg::*;

  localparam int LW = $clog2(MAX_FRAME + 2);
  localparam logic [LW-1:0] LEN_SAT = LW'(MAX_FRAME + 1);

  front_state_t state, state_next;
  logic [LW-1:0] flen;
  logic [15:0]   crc;
  logic [7:0]    head [6];
  logic [LW-1:0] last_len;
  logic [15:0]   last_crc;

  op_t           op;
  logic          accept;
  logic [15:0]   crc_new;
  logic [LW-1:0] len_new;

  // classification
  logic        bad, short_req, is_regs, is_bits, under, over, size_bad, drop;
  logic [15:0] start, qty, base;
  logic [10:0] count;
  logic [16:0] rel;
  logic [17:0] span, rlen;
  cmd_t        req_cmd, wr_cmd;

  assign op      = op_t'(items.op);
  assign accept  = items.valid && items.ready;
  assign crc_new = crc_byte(crc, items.rx_byte);
  assign len_new = (flen == LEN_SAT) ? flen : flen + 1'b1;

  always_comb begin
    bad       = (last_len > LW'(MAX_FRAME)) || (last_len < LW'(4)) || (last_crc != 16'h0000);
    short_req = last_len < LW'(8);
    is_regs   = head[1] == cfg.regs_fc;
    is_bits   = head[1] == cfg.bits_fc;
    start     = {head[2], head[3]};
    qty       = {head[4], head[5]};
    base      = is_regs ? cfg.reg_base  : cfg.bit_base;
    count     = is_regs ? cfg.reg_count : cfg.bit_count;
    rel       = {1'b0, start} - {1'b0, base};
    under     = start < base;
    span      = {2'b00, rel[15:0]} + {2'b00, qty};
    over      = span > {7'd0, count};
    rlen      = is_regs ? 18'd5 + {1'b0, qty, 1'b0}
                        : 18'd5 + (({2'b00, qty} + 18'd7) >> 3);
    size_bad  = (qty == 16'h0000) || (rlen > 18'(MAX_RESPONSE));
    drop      = bad || ((is_regs || is_bits) && short_req);

    req_cmd         = '0;
    req_cmd.regs    = is_regs;
    req_cmd.addr    = head[0];
    req_cmd.func    = head[1];
    req_cmd.rel     = rel[10:0];
    req_cmd.qty     = qty[10:0];
    req_cmd.bytecnt = 8'(rlen - 18'd5);
    priority if (!(is_regs || is_bits)) begin
      req_cmd.kind = CMD_EXC;
      req_cmd.code = EXC_FUNC;
    end else if (under || over) begin
      req_cmd.kind = CMD_EXC;
      req_cmd.code = EXC_ADDR;
    end else if (size_bad) begin
      req_cmd.kind = CMD_EXC;
      req_cmd.code = EXC_SIZE;
    end else begin
      req_cmd.kind = CMD_READ;
    end

    wr_cmd       = '0;
    wr_cmd.kind  = (op == OP_WBIT) ? CMD_WBIT : CMD_WREG;
    wr_cmd.index = items.point_index;
    wr_cmd.value = items.point_value;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IN:    if (accept && op == OP_BYTE && items.frame_end) state_next = F_CHECK;
      F_CHECK: if (drop || !full) state_next = F_IN;
      default: state_next = F_IN;
    endcase
  end

  // outputs
  always_comb begin
    items.ready = 1'b0;
    push        = 1'b0;
    push_cmd    = wr_cmd;
    unique case (state)
      F_IN: begin
        items.ready = !bstat.clearing && !full;
        push        = accept && (op == OP_WBIT || op == OP_WREG);
      end
      F_CHECK: begin
        push     = !drop && !full;
        push_cmd = req_cmd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IN;
      flen  <= '0;
      crc   <= CRC_INIT;
    end else begin
      state <= state_next;
      if (accept && op == OP_BYTE) begin
        if (items.frame_end) begin
          flen <= '0;
          crc  <= CRC_INIT;
        end else begin
          flen <= len_new;
          crc  <= crc_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_BYTE) begin
      if (flen < LW'(6)) head[flen[2:0]] <= items.rx_byte;
      if (items.frame_end) begin
        last_len <= len_new;
        last_crc <= crc_new;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/mrs_back.sv */
// Back end: owns the point and register stores, applies writes, builds responses.
// Depends on mrs_pkg and mrs_if.
`default_nettype none
module mrs_back #(
  parameter int POINTS = mrs_pkg::POINTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mrs_pkg::cfg_t cfg,
  input  wire mrs_pkg::cmd_t head_cmd,
  input  wire logic          empty,
  output logic               pop,
  output mrs_pkg::back_status_t bstat,
  mrs_out_if.source          results
);
  import mrs_pkg::*;

  localparam int DEPTH = (POINTS < STORE_MAX) ? POINTS : STORE_MAX;
  localparam int AW    = $clog2(DEPTH);

  logic          bit_mem [DEPTH];
  logic [15:0]   reg_mem [DEPTH];
  logic          bit_rd;
  logic [15:0]   reg_rd;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [AW-1:0] clr_addr;
  logic [1:0]  hcnt;
  logic [10:0] i;
  logic [7:0]  acc;
  logic [15:0] rdata;
  logic        sel;
  logic        oob_q;
  logic [15:0] crc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic          can_emit, emit, emit_last, emit_upd, rd_en;
  logic [7:0]    emit_byte, hbyte;
  logic [16:0]   idx;
  logic          oob, head_ok;
  logic          we_bit, we_reg, wbit;
  logic [AW-1:0] waddr;
  logic [15:0]   wreg;

  assign can_emit = !out_valid || results.ready;
  assign idx      = 17'(cur.regs ? cfg.reg_offset : cfg.bit_offset) + 17'(cur.rel) + 17'(i);
  // indexes past the implemented store were never written and read as zero
  assign oob      = idx >= 17'(DEPTH);
  assign head_ok  = 17'(head_cmd.index) < 17'(POINTS);

  assign results.valid   = out_valid;
  assign results.tx_byte = out_byte;
  assign results.tx_last = out_last;
  assign bstat.clearing  = (state == B_CLEAR);

  always_comb begin
    unique case (hcnt)
      2'd0:    hbyte = cur.addr;
      2'd1:    hbyte = (cur.kind == CMD_EXC) ? (cur.func | EXC_FLAG) : cur.func;
      default: hbyte = (cur.kind == CMD_EXC) ? cur.code : cur.bytecnt;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = B_IDLE;
      B_IDLE:  if (!empty && (head_cmd.kind == CMD_READ || head_cmd.kind == CMD_EXC))
                 state_next = B_HEAD;
      B_HEAD:  if (can_emit && hcnt == 2'd2) begin
                 if (cur.kind == CMD_EXC) state_next = B_CRCL;
                 else if (cur.regs)       state_next = B_RREQ;
                 else                     state_next = B_BREQ;
               end
      B_BREQ:  state_next = B_BCAP;
      B_BCAP:  if (i[2:0] == 3'd7 || i + 1'b1 == cur.qty) state_next = B_DATA;
               else state_next = B_BREQ;
      B_RREQ:  state_next = B_RCAP;
      B_RCAP:  state_next = B_DATA;
      B_DATA:  if (can_emit && !(cur.regs && !sel)) begin
                 if (i == cur.qty)  state_next = B_CRCL;
                 else if (cur.regs) state_next = B_RREQ;
                 else               state_next = B_BREQ;
               end
      B_CRCL:  if (can_emit) state_next = B_CRCH;
      B_CRCH:  if (can_emit) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = hbyte;
    emit_last = 1'b0;
    emit_upd  = 1'b0;
    rd_en     = 1'b0;
    we_bit    = 1'b0;
    we_reg    = 1'b0;
    waddr     = head_cmd.index[AW-1:0];
    wbit      = head_cmd.value[0];
    wreg      = head_cmd.value;
    unique case (state)
      B_CLEAR: begin
        we_bit = 1'b1;
        we_reg = 1'b1;
        waddr  = clr_addr;
        wbit   = 1'b0;
        wreg   = '0;
      end
      B_IDLE: begin
        pop    = !empty;
        we_bit = !empty && head_cmd.kind == CMD_WBIT && head_ok;
        we_reg = !empty && head_cmd.kind == CMD_WREG && head_ok;
      end
      B_HEAD: begin
        emit     = can_emit;
        emit_upd = 1'b1;
      end
      B_BREQ, B_RREQ: rd_en = 1'b1;
      B_DATA: begin
        emit      = can_emit;
        emit_upd  = 1'b1;
        emit_byte = cur.regs ? (sel ? rdata[7:0] : rdata[15:8]) : acc;
      end
      B_CRCL: begin
        emit      = can_emit;
        emit_byte = crc[7:0];
      end
      B_CRCH: begin
        emit      = can_emit;
        emit_byte = crc[15:8];
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_bit) bit_mem[waddr] <= wbit;
    if (we_reg) reg_mem[waddr] <= wreg;
    if (rd_en) begin
      bit_rd <= bit_mem[idx[AW-1:0]];
      reg_rd <= reg_mem[idx[AW-1:0]];
      oob_q  <= oob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (emit)                out_valid <= 1'b1;
      else if (results.ready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
      if (emit_upd) crc <= crc_byte(crc, emit_byte);
    end
    unique case (state)
      B_IDLE: if (pop) begin
        cur  <= head_cmd;
        hcnt <= '0;
        i    <= '0;
        acc  <= '0;
        sel  <= 1'b0;
        crc  <= CRC_INIT;
      end
      B_HEAD: if (can_emit) hcnt <= hcnt + 1'b1;
      B_BCAP: begin
        acc <= acc | (8'(bit_rd && !oob_q) << i[2:0]);
        i   <= i + 1'b1;
      end
      B_RCAP: begin
        rdata <= oob_q ? 16'h0000 : reg_rd;
        i     <= i + 1'b1;
      end
      B_DATA: if (can_emit) begin
        if (cur.regs) sel <= !sel;
        else          acc <= '0;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/mrs_checker.sv */
// Port-level checks for the read responder, bound to the top level.
// Depends on modbus_rtu_slave_read_responder_core.
`default_nettype none
module mrs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);
  a_out_idle_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid right after reset");

  a_no_req_during_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during store clear");

  a_clear_lasts: assert property (@(posedge clk) rst |-> ##2 !in_ready)
    else $error("store clear ended too early");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled response byte changed");
endmodule

bind modbus_rtu_slave_read_responder_core mrs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_byte  (results.tx_byte),
  .out_last  (results.tx_last)
);
`default_nettype wire

/* tb/sv/modbus_rtu_slave_read_responder_core_test.sv */
// Self-checking test of the Modbus RTU read responder: request frames, point and register
// writes in; response bytes out. Uses mrs_pkg and the mrs_in_if / mrs_out_if channels.
`timescale 1ns / 1ps
module modbus_rtu_slave_read_responder_core_test;
  import mrs_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [7:0]  rx;
    logic        fend;
    logic [9:0]  idx;
    logic [15:0] val;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  mrs_in_if  items ();
  mrs_out_if results ();

  modbus_rtu_slave_read_responder_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(items.sink), .results(results.source)
  );

  always #5 clk = ~clk;

  // requests waiting to be offered, and response bytes {last, byte} still owed
  req_t       pending_reqs[$];
  logic [8:0] owed_bytes[$];
  int         errors = 0;
  bit         in_took = 1'b0;
  bit         calm = 1'b0;      // no random idling on either side while set
  bit         hold_go = 1'b0;
  bit         hold_used = 1'b0;
  int         hold_left = 0;

  // shadow of the block: configuration and state
  logic [7:0]  m_bits_fc, m_regs_fc;
  logic [15:0] m_bit_base, m_reg_base;
  logic [10:0] m_bit_count, m_reg_count;
  logic [9:0]  m_bit_offset, m_reg_offset;
  logic [7:0]  m_head[8];
  int unsigned m_flen;
  logic [15:0] m_crc;
  logic        m_bit_mem[1024];
  logic [15:0] m_reg_mem[1024];

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] crc16(input logic [7:0] body[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (body[k]) c = crc16_step(c, body[k]);
    return c;
  endfunction

  // append CRC (low byte first) and queue the response bytes as owed
  task automatic owe_frame(input logic [7:0] body[$]);
    logic [15:0] c;
    c = crc16(body);
    body.insert(body.size(), c[7:0]);
    body.insert(body.size(), c[15:8]);
    foreach (body[k]) owed_bytes.insert(owed_bytes.size(), {k == body.size() - 1, body[k]});
  endtask

  task automatic owe_exception(input logic [7:0] code);
    logic [7:0] b[$];
    b = '{m_head[0], m_head[1] | EXC_FLAG, code};
    owe_frame(b);
  endtask

  // one accepted request -> the response bytes it causes
  task automatic predict_response(input req_t r);
    int unsigned len, start, qty, base, cnt, offs, rlen, ix;
    logic [15:0] c, v;
    logic [7:0]  b[$];
    bit          regs;
    case (r.op)
      OP_WBIT: m_bit_mem[r.idx] = r.val[0];
      OP_WREG: m_reg_mem[r.idx] = r.val;
      OP_BYTE: begin
        if (m_flen < 8) m_head[m_flen] = r.rx;
        m_crc = crc16_step(m_crc, r.rx);
        if (m_flen <= MAX_FRAME_DEF) m_flen++;
        if (!r.fend) return;
        len = m_flen;
        c = m_crc;
        m_flen = 0;
        m_crc = 16'hFFFF;
        if (len > MAX_FRAME_DEF || len < 4 || c != 16'h0) return;
        // register read wins when both function codes match
        if (m_head[1] == m_regs_fc) regs = 1'b1;
        else if (m_head[1] == m_bits_fc) regs = 1'b0;
        else begin
          owe_exception(EXC_FUNC);
          return;
        end
        if (len < 8) return;
        start = {m_head[2], m_head[3]};
        qty   = {m_head[4], m_head[5]};
        base  = regs ? m_reg_base : m_bit_base;
        cnt   = regs ? m_reg_count : m_bit_count;
        offs  = regs ? m_reg_offset : m_bit_offset;
        if (start < base || (start - base) + qty > cnt) begin
          owe_exception(EXC_ADDR);
          return;
        end
        rlen = regs ? 5 + 2 * qty : 5 + (qty + 7) / 8;
        if (qty == 0 || rlen > MAX_RESPONSE_DEF) begin
          owe_exception(EXC_SIZE);
          return;
        end
        b = '{m_head[0], m_head[1], 8'(rlen - 5)};
        for (int k = 0; k < rlen - 5; k++) b.insert(b.size(), 8'h00);
        for (int unsigned i = 0; i < qty; i++) begin
          ix = offs + (start - base) + i;
          if (regs) begin
            v = (ix < 1024) ? m_reg_mem[ix] : 16'h0;
            b[3 + 2 * i] = v[15:8];
            b[4 + 2 * i] = v[7:0];
          end else if (ix < 1024 && m_bit_mem[ix]) begin
            b[3 + i / 8] = b[3 + i / 8] | (8'h01 << (i % 8));
          end
        end
        owe_frame(b);
      end
      default: ;  // OP_NONE is dropped
    endcase
  endtask

  // ---------------- request side ----------------
  always @(posedge clk) begin
    if (!rst && items.valid && items.ready) begin
      predict_response(req_t'{op_t'(items.op), items.rx_byte, items.frame_end,
                              items.point_index, items.point_value});
      void'(pending_reqs.pop_front());
      in_took = 1'b1;
    end
  end

  // hold the current request until taken; otherwise offer the next one or idle
  always @(negedge clk) begin
    if (!rst && (!items.valid || in_took)) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
        items.valid       <= 1'b1;
        items.op          <= pending_reqs[0].op;
        items.rx_byte     <= pending_reqs[0].rx;
        items.frame_end   <= pending_reqs[0].fend;
        items.point_index <= pending_reqs[0].idx;
        items.point_value <= pending_reqs[0].val;
      end else begin
        items.valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // ---------------- response side ----------------
  // one long back-pressure window, counted here so the block fills and stalls input
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_go && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) results.ready <= 1'b0;
    else results.ready <= calm || $urandom_range(99) >= 10;
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t: response byte expected none actual %02h last %0b", $time,
                 results.tx_byte, results.tx_last);
        errors++;
      end else begin
        if (results.tx_byte !== owed_bytes[0][7:0]) begin
          $display("%0t: tx_byte expected %02h actual %02h", $time,
                   owed_bytes[0][7:0], results.tx_byte);
          errors++;
        end
        if (results.tx_last !== owed_bytes[0][8]) begin
          $display("%0t: tx_last expected %0b actual %0b", $time,
                   owed_bytes[0][8], results.tx_last);
          errors++;
        end
        void'(owed_bytes.pop_front());
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic cfg_write(input cfg_idx_t i, input logic [15:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_data  <= d;
    case (i)
      CFG_BITS_FC:    m_bits_fc    = d[7:0];
      CFG_REGS_FC:    m_regs_fc    = d[7:0];
      CFG_BIT_BASE:   m_bit_base   = d;
      CFG_BIT_COUNT:  m_bit_count  = d[10:0];
      CFG_BIT_OFFSET: m_bit_offset = d[9:0];
      CFG_REG_BASE:   m_reg_base   = d;
      CFG_REG_COUNT:  m_reg_count  = d[10:0];
      default:        m_reg_offset = d[9:0];
    endcase
  endtask

  task automatic cfg_all(input logic [7:0] bfc, input logic [7:0] rfc,
                         input logic [15:0] bbase, input logic [10:0] bcnt,
                         input logic [9:0] boff, input logic [15:0] rbase,
                         input logic [10:0] rcnt, input logic [9:0] roff);
    cfg_write(CFG_BITS_FC, bfc);
    cfg_write(CFG_REGS_FC, rfc);
    cfg_write(CFG_BIT_BASE, bbase);
    cfg_write(CFG_BIT_COUNT, bcnt);
    cfg_write(CFG_BIT_OFFSET, boff);
    cfg_write(CFG_REG_BASE, rbase);
    cfg_write(CFG_REG_COUNT, rcnt);
    cfg_write(CFG_REG_OFFSET, roff);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is taken and every owed byte has come, then let
  // trailing no-response work (bit reads take a store read and a capture per point) drain
  task automatic drain();
    while (pending_reqs.size() > 0 || items.valid || owed_bytes.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic put_store(input op_t op, input logic [9:0] idx, input logic [15:0] val);
    pending_reqs.insert(pending_reqs.size(), req_t'{op, 8'($urandom), 1'($urandom), idx, val});
  endtask

  // queue a frame; crc_ok=0 corrupts the received CRC
  task automatic put_frame(input logic [7:0] body[$], input bit crc_ok);
    logic [15:0] c;
    c = crc16(body) ^ (crc_ok ? 16'h0 : 16'h0001 << $urandom_range(15));
    body.insert(body.size(), c[7:0]);
    body.insert(body.size(), c[15:8]);
    foreach (body[k])
      pending_reqs.insert(pending_reqs.size(),
                          req_t'{OP_BYTE, body[k], k == body.size() - 1,
                                 10'($urandom), 16'($urandom)});
  endtask

  task automatic put_read(input logic [7:0] fc, input logic [15:0] start,
                          input logic [15:0] qty, input bit crc_ok);
    logic [7:0] b[$];
    b = '{8'($urandom), fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
    put_frame(b, crc_ok);
  endtask

  // mostly well-formed reads near the exposed window, the rest writes and noise
  task automatic random_traffic(input int n);
    logic [7:0]  fc, b[$];
    logic [15:0] start, qty;
    bit          regs;
    int          sel, base0, cnt0;
    int          before_n;
    before_n = 0;
    while (before_n < n) begin
      sel = $urandom_range(99);
      if (sel < 20) begin
        put_store($urandom_range(1) ? OP_WBIT : OP_WREG, 10'($urandom), 16'($urandom));
        before_n++;
      end else if (sel < 85) begin
        regs = $urandom_range(1);
        fc = (sel < 80) ? (regs ? m_regs_fc : m_bits_fc) : 8'($urandom);
        base0 = regs ? m_reg_base : m_bit_base;
        cnt0  = regs ? m_reg_count : m_bit_count;
        start = ($urandom_range(9) == 0) ? 16'($urandom) :
                16'(base0 + $urandom_range(cnt0));
        case ($urandom_range(9))
          0: qty = 16'h0;
          1: qty = 16'($urandom);
          default: qty = 16'($urandom_range(1, regs ? 32 : 500));
        endcase
        put_read(fc, start, qty, $urandom_range(9) != 0);
        before_n += 8;
      end else if (sel < 93) begin
        // short or odd-length frames, some with a valid CRC
        b = {};
        repeat ($urandom_range(0, 9)) b.insert(b.size(), 8'($urandom));
        if (b.size() > 1 && $urandom_range(1)) b[1] = m_regs_fc;
        put_frame(b, $urandom_range(3) != 0);
        before_n += b.size() + 2;
      end else begin
        pending_reqs.insert(pending_reqs.size(), req_t'{OP_NONE, 8'($urandom),
                            1'($urandom), 10'($urandom), 16'($urandom)});
        before_n++;
      end
    end
  endtask

  // ---------------- test sequence ----------------
  initial begin
    logic [7:0] b[$];
    items.valid = 1'b0;
    items.op = OP_BYTE;
    items.rx_byte = '0;
    items.frame_end = 1'b0;
    items.point_index = '0;
    items.point_value = '0;
    results.ready = 1'b0;
    m_bits_fc = 8'd2;  m_regs_fc = 8'd3;
    m_bit_base = '0;   m_bit_count = '0;  m_bit_offset = '0;
    m_reg_base = '0;   m_reg_count = '0;  m_reg_offset = '0;
    m_flen = 0;
    m_crc = 16'hFFFF;
    foreach (m_head[k]) m_head[k] = '0;
    foreach (m_bit_mem[k]) begin
      m_bit_mem[k] = 1'b0;
      m_reg_mem[k] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: nothing exposed, so a read hits the address exception
    put_read(8'd3, 16'h0, 16'd1, 1'b1);
    put_read(8'd2, 16'h0, 16'd1, 1'b1);
    drain();

    // window that runs past the end of the register store (reads as zero);
    // offered back to back with no idling on either side
    calm = 1'b1;
    cfg_all(8'd1, 8'd3, 16'h0010, 11'd100, 10'd5, 16'h0100, 11'd40, 10'd1000);
    put_store(OP_WBIT, 10'd5, 16'hFFFF);
    put_store(OP_WBIT, 10'd7, 16'h0001);
    put_store(OP_WREG, 10'd1000, 16'hA55A);
    put_store(OP_WREG, 10'd1023, 16'hFFFF);
    put_store(OP_WREG, 10'd0, 16'h0000);
    put_read(8'd1, 16'h0010, 16'd11, 1'b1);       // packed bits
    put_read(8'd3, 16'h0100, 16'd29, 1'b1);       // regs, largest that fits
    put_read(8'd3, 16'h0100, 16'd30, 1'b1);       // response too long
    put_read(8'd3, 16'h0100, 16'd0, 1'b1);        // zero quantity
    put_read(8'd3, 16'h00FF, 16'd1, 1'b1);        // start below base
    put_read(8'd3, 16'h0120, 16'd9, 1'b1);        // runs past the count
    put_read(8'd1, 16'h0010, 16'd1, 1'b0);        // bad CRC
    put_read(8'h7F, 16'h0, 16'd1, 1'b1);          // unknown function
    b = '{8'h11, 8'h3F};
    put_frame(b, 1'b1);                           // 4-byte unknown function
    b = '{8'h11, 8'd3, 8'h01};
    put_frame(b, 1'b1);                           // known function, too short
    b = '{8'h11};
    put_frame(b, 1'b1);                           // fewer than 4 bytes
    pending_reqs.insert(pending_reqs.size(), req_t'{OP_NONE, 8'hFF, 1'b1, 10'h3FF, 16'hFFFF});
    b = '{8'h22, 8'd3, 8'h01, 8'h00, 8'h00, 8'h02};
    repeat (249) b.insert(b.size(), 8'($urandom));
    put_frame(b, 1'b1);                           // overlong frame, 257 bytes
    put_read(8'd3, 16'h0100, 16'd2, 1'b1);
    drain();
    calm = 1'b0;

    // long output stall while a response is pending: queued writes fill the block
    hold_go = 1'b1;
    put_read(8'd3, 16'h0100, 16'd2, 1'b1);
    repeat (8) put_store(OP_WREG, 10'($urandom), 16'($urandom));
    drain();

    // extremes of every register
    cfg_all(8'hFF, 8'h00, 16'hFFFF, 11'd1024, 10'd1023, 16'h0000, 11'd1024, 10'd0);
    put_read(8'hFF, 16'hFFFF, 16'd1, 1'b1);
    put_read(8'h00, 16'h0000, 16'd1, 1'b1);
    random_traffic(10);
    drain();

    // both function codes equal: register read wins
    cfg_all(8'd4, 8'd4, 16'h0200, 11'd512, 10'd300, 16'h0040, 11'd0, 10'd512);
    put_read(8'd4, 16'h0040, 16'd1, 1'b1);
    drain();
    cfg_all(8'd4, 8'd4, 16'h0200, 11'd512, 10'd300, 16'h0040, 11'd64, 10'd512);
    random_traffic(10);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* modbus_rtu_slave_read_responder_core.f */
rtl/mrs_pkg.sv
rtl/mrs_if.sv
rtl/mrs_fifo.sv
rtl/mrs_front.sv
rtl/mrs_back.sv
rtl/modbus_rtu_slave_read_responder_core.sv
rtl/mrs_checker.sv
tb/sv/modbus_rtu_slave_read_responder_core_test.sv
